FILE: hdl/gis_pkg.sv
`timescale 1ns / 1ps

package gis_pkg;

	localparam int PIXEL_W    = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CONTRAST_W = 16;
	localparam int Q15_FRAC   = 15;

	// the shared divider always produces this many quotient bits
	localparam int QUOT_W     = 16;

	// contrast numerator (max-min) << 15 and denominator max+min
	localparam int CON_NUM_W  = PIXEL_W + Q15_FRAC;
	localparam int CON_DEN_W  = PIXEL_W + 1;

	localparam logic [PIXEL_W-1:0]    LEVEL_MAX = 8'hFF;
	localparam logic [CONTRAST_W-1:0] Q15_ONE   = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_CON_GO,
		ST_CON_WAIT
	} gis_state_t;

endpackage

FILE: hdl/gis_if.sv
`timescale 1ns / 1ps

interface gis_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [gis_pkg::PIXEL_W-1:0]  pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

interface gis_result_if;
	logic                           valid;
	logic                           ready;
	logic [gis_pkg::PIXEL_W-1:0]    mean_level;
	logic [gis_pkg::PIXEL_W-1:0]    min_level;
	logic [gis_pkg::PIXEL_W-1:0]    max_level;
	logic [gis_pkg::CONTRAST_W-1:0] contrast;
	logic                           contrast_undefined;

	modport source(output valid, output mean_level, output min_level, output max_level,
		output contrast, output contrast_undefined, input ready);
	modport sink(input valid, input mean_level, input min_level, input max_level,
		input contrast, input contrast_undefined, output ready);
endinterface

interface gis_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gis_pkg::CFG_IDX_W-1:0] index;
	logic [gis_pkg::CFG_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/gis_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; the quotient must fit QUOT_W bits
module gis_divider #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             num,
	input  logic [DEN_W-1:0]             den,
	output logic                         done,
	output logic [gis_pkg::QUOT_W-1:0]   quot
);

	localparam int STEP_W = $clog2(gis_pkg::QUOT_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [DEN_W-1:0]            rem_q;
	logic [DEN_W-1:0]            den_q;
	logic [gis_pkg::QUOT_W-1:0]  quo_q;

	logic [DEN_W:0]              trial;
	logic [DEN_W:0]              diff;
	logic                        fits;

	assign trial = {rem_q, quo_q[gis_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(gis_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// low dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> gis_pkg::QUOT_W);
			quo_q <= num[gis_pkg::QUOT_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[gis_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: hdl/gray_image_statistics_unit.sv
`timescale 1ns / 1ps

// Gray image statistics. Pixels of a frame enter on the pixels channel, one per
// cycle while ready is high; each transaction is one 8-bit gray sample. The frame
// size comes from the cfg channel (index 0 width, index 1 height, always ready),
// clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT. Once width*height pixels are in,
// the block stops taking pixels, runs the mean and the contrast through one
// shared bit-serial divider and presents one transaction on the results
// channel: mean, min, max, Q1.15 Michelson contrast and a flag for an
// all-black frame. The result appears after the contrast division is done
// (after the mean division for an all-black frame, which skips the contrast
// division); pixels of the next frame are taken again from then on, one per
// cycle. A result waits in an output register until taken: pixels keep
// flowing meanwhile, but the last pixel of the following frame is held off
// until the previous result is gone. Reset sets width and height to 1, clears
// the running statistics and drops results.valid.
module gray_image_statistics_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	gis_cfg_if.sink     cfg,
	gis_pixel_if.sink   pixels,
	gis_result_if.source results
);

	localparam int W_W     = $clog2(MAX_WIDTH + 1);
	localparam int H_W     = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SUM_W   = CNT_W + gis_pkg::PIXEL_W;
	localparam int DIV_NUM_W = (SUM_W > gis_pkg::CON_NUM_W) ? SUM_W : gis_pkg::CON_NUM_W;
	localparam int DIV_DEN_W = (CNT_W > gis_pkg::CON_DEN_W) ? CNT_W : gis_pkg::CON_DEN_W;

	function automatic logic [W_W-1:0] clamp_w(input logic [gis_pkg::CFG_W-1:0] v);
		logic [W_W-1:0] r;
		if (v == '0)
			r = W_W'(1);
		else if (32'(v) > MAX_WIDTH)
			r = W_W'(MAX_WIDTH);
		else
			r = W_W'(v);
		return r;
	endfunction

	function automatic logic [H_W-1:0] clamp_h(input logic [gis_pkg::CFG_W-1:0] v);
		logic [H_W-1:0] r;
		if (v == '0)
			r = H_W'(1);
		else if (32'(v) > MAX_HEIGHT)
			r = H_W'(MAX_HEIGHT);
		else
			r = H_W'(v);
		return r;
	endfunction

	// frame geometry
	logic [W_W-1:0]        w_eff_q;
	logic [H_W-1:0]        h_eff_q;
	logic [CNT_W-1:0]      target_q;
	logic [W_W-1:0]        w_new;
	logic [H_W-1:0]        h_new;
	logic [W_W+H_W-1:0]    area;
	logic                  cfg_wr;

	// running statistics
	logic [SUM_W-1:0]            sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [gis_pkg::PIXEL_W-1:0] min_q;
	logic [gis_pkg::PIXEL_W-1:0] max_q;
	logic [CNT_W-1:0]            count_nxt;
	logic                        last_pix;
	logic                        pix_acc;

	// result register
	logic                          out_valid_q;
	logic [gis_pkg::PIXEL_W-1:0]   res_mean_q;
	logic [gis_pkg::PIXEL_W-1:0]   res_min_q;
	logic [gis_pkg::PIXEL_W-1:0]   res_max_q;
	logic [gis_pkg::CONTRAST_W-1:0] res_contrast_q;
	logic                          res_undef_q;

	// sequencer
	gis_pkg::gis_state_t state_q, state_d;
	logic                div_start;
	logic                div_sel_con;
	logic                mean_cap;
	logic                finish;
	logic                finish_undef;
	logic                den_zero;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                div_done;
	logic [gis_pkg::QUOT_W-1:0] div_quot;

	// configuration
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	always_comb begin
		w_new = w_eff_q;
		h_new = h_eff_q;
		if (cfg_wr) begin
			case (cfg.index)
				gis_pkg::REG_IMAGE_WIDTH:  w_new = clamp_w(cfg.data);
				gis_pkg::REG_IMAGE_HEIGHT: h_new = clamp_h(cfg.data);
				default: ;
			endcase
		end
	end

	assign area = {{H_W{1'b0}}, w_new} * {{W_W{1'b0}}, h_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q  <= W_W'(1);
			h_eff_q  <= H_W'(1);
			target_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			w_eff_q  <= w_new;
			h_eff_q  <= h_new;
			target_q <= CNT_W'(area);
		end
	end

	// pixel intake
	assign count_nxt    = count_q + 1'b1;
	assign last_pix     = count_nxt >= target_q;
	assign pixels.ready = (state_q == gis_pkg::ST_ACCUM) && !(last_pix && out_valid_q);
	assign pix_acc      = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= gis_pkg::LEVEL_MAX;
			max_q   <= '0;
		end else if (finish) begin
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= gis_pkg::LEVEL_MAX;
			max_q   <= '0;
		end else if (pix_acc) begin
			sum_q   <= sum_q + SUM_W'(pixels.pixel);
			count_q <= count_nxt;
			if (pixels.pixel < min_q)
				min_q <= pixels.pixel;
			if (pixels.pixel > max_q)
				max_q <= pixels.pixel;
		end
	end

	// divider operands: mean first, then contrast
	assign den_zero = (max_q == '0) && (min_q == '0);
	assign div_num  = div_sel_con
		? DIV_NUM_W'({max_q - min_q, {gis_pkg::Q15_FRAC{1'b0}}})
		: DIV_NUM_W'(sum_q);
	assign div_den  = div_sel_con
		? DIV_DEN_W'({1'b0, max_q} + {1'b0, min_q})
		: DIV_DEN_W'(count_q);

	gis_divider #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(DIV_DEN_W)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gis_pkg::ST_ACCUM;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_sel_con  = 1'b0;
		mean_cap     = 1'b0;
		finish       = 1'b0;
		finish_undef = 1'b0;
		case (state_q)
			gis_pkg::ST_ACCUM: begin
				if (pix_acc && last_pix)
					state_d = gis_pkg::ST_MEAN_GO;
			end
			gis_pkg::ST_MEAN_GO: begin
				div_start = 1'b1;
				state_d   = gis_pkg::ST_MEAN_WAIT;
			end
			gis_pkg::ST_MEAN_WAIT: begin
				if (div_done) begin
					mean_cap = 1'b1;
					state_d  = gis_pkg::ST_CON_GO;
				end
			end
			gis_pkg::ST_CON_GO: begin
				div_sel_con = 1'b1;
				if (den_zero) begin
					// all-black frame, contrast has no value
					finish       = 1'b1;
					finish_undef = 1'b1;
					state_d      = gis_pkg::ST_ACCUM;
				end else begin
					div_start = 1'b1;
					state_d   = gis_pkg::ST_CON_WAIT;
				end
			end
			gis_pkg::ST_CON_WAIT: begin
				if (div_done) begin
					finish  = 1'b1;
					state_d = gis_pkg::ST_ACCUM;
				end
			end
			default: state_d = gis_pkg::ST_ACCUM;
		endcase
	end

	// result register, free whenever a frame closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (mean_cap)
			res_mean_q <= div_quot[gis_pkg::PIXEL_W-1:0];
		if (finish) begin
			res_min_q      <= min_q;
			res_max_q      <= max_q;
			res_contrast_q <= finish_undef ? '0 : div_quot;
			res_undef_q    <= finish_undef;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.mean_level         = res_mean_q;
	assign results.min_level          = res_min_q;
	assign results.max_level          = res_max_q;
	assign results.contrast           = res_contrast_q;
	assign results.contrast_undefined = res_undef_q;

endmodule

FILE: hdl/gis_checker.sv
`timescale 1ns / 1ps

module gis_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [gis_pkg::PIXEL_W-1:0]    mean_level,
	input logic [gis_pkg::PIXEL_W-1:0]    min_level,
	input logic [gis_pkg::PIXEL_W-1:0]    max_level,
	input logic [gis_pkg::CONTRAST_W-1:0] contrast,
	input logic                           contrast_undefined
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transaction completed");

	a_black_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && contrast_undefined |->
			contrast == '0 && max_level == '0 && min_level == '0 && mean_level == '0)
		else $error("undefined contrast on a frame that is not all black");

	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> min_level <= mean_level && mean_level <= max_level)
		else $error("mean outside min..max");

	a_contrast_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !contrast_undefined |->
			contrast <= gis_pkg::Q15_ONE && ((contrast == '0) == (max_level == min_level)))
		else $error("contrast inconsistent with min and max");

endmodule

bind gray_image_statistics_unit gis_checker u_gis_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (results.valid),
	.res_ready         (results.ready),
	.mean_level        (results.mean_level),
	.min_level         (results.min_level),
	.max_level         (results.max_level),
	.contrast          (results.contrast),
	.contrast_undefined(results.contrast_undefined)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int PIXEL_W    = gis_pkg::PIXEL_W;
	localparam int CFG_W      = gis_pkg::CFG_W;
	localparam int CFG_IDX_W  = gis_pkg::CFG_IDX_W;
	localparam int CONTRAST_W = gis_pkg::CONTRAST_W;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [PIXEL_W-1:0]    mean_level;
		logic [PIXEL_W-1:0]    min_level;
		logic [PIXEL_W-1:0]    max_level;
		logic [CONTRAST_W-1:0] contrast;
		logic                  contrast_undefined;
	} frame_stats_t;

	typedef enum {PAT_RANDOM, PAT_BLACK, PAT_FLAT, PAT_NARROW, PAT_RAILS} pixel_pattern_t;
	typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic clk;
	logic arst_n;

	gis_cfg_if    cfg_bus();
	gis_pixel_if  pix_bus();
	gis_result_if res_bus();

	gray_image_statistics_unit #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pixels(pix_bus),
		.results(res_bus)
	);

	// predictor copy of the registers and the running statistics
	logic [CFG_W-1:0]   width_cfg = 11'd1;
	logic [CFG_W-1:0]   height_cfg = 11'd1;
	int unsigned        level_sum = 0;
	int unsigned        level_count = 0;
	logic [PIXEL_W-1:0] level_min = gis_pkg::LEVEL_MAX;
	logic [PIXEL_W-1:0] level_max = '0;

	logic [PIXEL_W-1:0] pixel_queue[$];
	frame_stats_t       expected_stats[$];

	int   pixels_pushed = 0;
	int   pixels_accepted = 0;
	int   frames_checked = 0;
	int   config_writes = 0;
	int   error_count = 0;
	logic gapless_phase = 1'b0;

	int       hold_request = 0;
	int       hold_ack = 0;
	int       hold_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_cycle = 0;

	function automatic int unsigned frame_dim(input logic [CFG_W-1:0] v,
		input int unsigned limit);
		if (v == 0)
			return 1;
		if (32'(v) > limit)
			return limit;
		return 32'(v);
	endfunction

	function automatic int unsigned frame_pixels();
		return frame_dim(width_cfg, MAX_WIDTH) * frame_dim(height_cfg, MAX_HEIGHT);
	endfunction

	// folds one pixel into the statistics; returns 1 when it closes the frame
	function automatic bit accumulate_pixel(input logic [PIXEL_W-1:0] p,
		output frame_stats_t stats);
		int unsigned span;
		int unsigned level_total;
		stats = '0;
		level_sum += 32'(p);
		level_count++;
		if (p < level_min)
			level_min = p;
		if (p > level_max)
			level_max = p;
		if (level_count < frame_pixels())
			return 0;
		span = 32'(level_max) - 32'(level_min);
		level_total = 32'(level_max) + 32'(level_min);
		stats.mean_level = PIXEL_W'(level_sum / level_count);
		stats.min_level = level_min;
		stats.max_level = level_max;
		if (level_total == 0) begin
			stats.contrast = '0;
			stats.contrast_undefined = 1'b1;
		end else begin
			stats.contrast = CONTRAST_W'((span * 32'(gis_pkg::Q15_ONE)) / level_total);
			stats.contrast_undefined = 1'b0;
		end
		level_sum = 0;
		level_count = 0;
		level_min = gis_pkg::LEVEL_MAX;
		level_max = '0;
		return 1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// pixel sender: bursts of random length with random gaps
	always @(posedge clk) begin : pixel_driver
		frame_stats_t stats;
		logic         next_valid;
		int           burst_left;
		int           gap_left;
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (pix_bus.valid && pix_bus.ready) begin
				if (accumulate_pixel(pix_bus.pixel, stats))
					expected_stats.push_back(stats);
				pixels_accepted++;
			end
			if (!pix_bus.valid || pix_bus.ready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pixel_queue.size() > 0) begin
					next_valid = 1'b1;
					pix_bus.pixel <= pixel_queue.pop_front();
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					burst_left--;
					if (burst_left == 0 && !gapless_phase)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				pix_bus.valid <= next_valid;
			end
		end
	end

	// long receiver hold-off, started by the stimulus
	always @(posedge clk) begin : receiver_hold
		if (hold_request != hold_ack) begin
			hold_ack <= hold_request;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result receiver and checker
	always @(posedge clk) begin : stats_monitor
		frame_stats_t want;
		logic         ready_next;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_stats.size() == 0) begin
					$display("%0t: unexpected result transaction, mean %0d min %0d max %0d",
						$time, res_bus.mean_level, res_bus.min_level, res_bus.max_level);
					error_count++;
				end else begin
					want = expected_stats.pop_front();
					check_field("mean_level", 32'(want.mean_level),
						32'(res_bus.mean_level));
					check_field("min_level", 32'(want.min_level), 32'(res_bus.min_level));
					check_field("max_level", 32'(want.max_level), 32'(res_bus.max_level));
					check_field("contrast", 32'(want.contrast), 32'(res_bus.contrast));
					check_field("contrast_undefined", 32'(want.contrast_undefined),
						32'(res_bus.contrast_undefined));
					frames_checked++;
				end
			end
			rx_cycle++;
			if (rx_cycle % 97 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_ALWAYS:   ready_next = 1'b1;
				RX_HALF:     ready_next = 1'($urandom_range(0, 1));
				RX_SPARSE:   ready_next = ($urandom_range(0, 3) == 0);
				default:     ready_next = (rx_cycle % 3 != 0);
			endcase
			res_bus.ready <= ready_next && (hold_left == 0);
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		if (idx == gis_pkg::REG_IMAGE_WIDTH)
			width_cfg = value[CFG_W-1:0];
		else
			height_cfg = value[CFG_W-1:0];
		config_writes++;
	endtask

	task automatic set_frame_size(input int unsigned w, input int unsigned h);
		write_register(gis_pkg::REG_IMAGE_WIDTH, w);
		write_register(gis_pkg::REG_IMAGE_HEIGHT, h);
	endtask

	task automatic push_pixel(input logic [PIXEL_W-1:0] p);
		pixel_queue.push_back(p);
		pixels_pushed++;
	endtask

	task automatic queue_frame(input int n, input pixel_pattern_t pattern);
		logic [PIXEL_W-1:0] level;
		logic [PIXEL_W-1:0] p;
		level = 8'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			case (pattern)
				PAT_RANDOM: p = 8'($urandom_range(0, 255));
				PAT_BLACK:  p = '0;
				PAT_FLAT:   p = level;
				PAT_NARROW: p = (level > 247) ? level - 8'($urandom_range(0, 7))
					: level + 8'($urandom_range(0, 7));
				default:    p = $urandom_range(0, 1) ? gis_pkg::LEVEL_MAX : '0;
			endcase
			push_pixel(p);
		end
	endtask

	// idle means every pixel taken and every result back
	task automatic wait_idle();
		while (pixels_accepted != pixels_pushed || expected_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int w;
		int h;
		int target;
		int frames;
		int random_pixels;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = gis_pkg::REG_IMAGE_WIDTH;
		cfg_bus.data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		res_bus.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset size 1x1: black frame, white frame, dim frame
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd1);
		wait_idle();
		// zero dimensions act as one
		set_frame_size(0, 0);
		push_pixel(8'd128);
		push_pixel(8'd0);
		wait_idle();
		set_frame_size(2, 1);
		push_pixel(8'd255);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd1);
		push_pixel(8'd254);
		push_pixel(8'd255);
		wait_idle();
		write_register(gis_pkg::REG_IMAGE_WIDTH, 3);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd0);
		wait_idle();
		// shrink the frame after two pixels: the next pixel closes it
		write_register(gis_pkg::REG_IMAGE_WIDTH, 4);
		push_pixel(8'd10);
		push_pixel(8'd200);
		wait_idle();
		write_register(gis_pkg::REG_IMAGE_WIDTH, 1);
		push_pixel(8'd77);
		wait_idle();
		write_register(gis_pkg::REG_IMAGE_HEIGHT, 2);
		push_pixel(8'd9);
		push_pixel(8'd8);
		wait_idle();

		// receiver holds off while small frames keep coming
		set_frame_size(2, 2);
		gapless_phase = 1'b1;
		hold_request++;
		for (int i = 0; i < 20; i++)
			queue_frame(4, PAT_RANDOM);
		wait_idle();
		gapless_phase = 1'b0;

		// oversized dimensions keep a short run open until the size shrinks
		set_frame_size(2047, 2047);
		queue_frame(24, PAT_RANDOM);
		wait_idle();
		set_frame_size(1, 1);
		push_pixel(8'd200);
		wait_idle();

		random_pixels = 0;
		while (random_pixels < 320) begin
			case ($urandom_range(0, 9))
				0: begin
					w = 0;
					h = $urandom_range(1, 6);
				end
				1: begin
					w = $urandom_range(1, 6);
					h = 0;
				end
				2: begin
					w = $urandom_range(9, 16);
					h = $urandom_range(1, 2);
				end
				default: begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 4);
				end
			endcase
			set_frame_size(w, h);
			gapless_phase = ($urandom_range(0, 3) == 0);
			target = frame_pixels();
			frames = $urandom_range(1, 4);
			for (int f = 0; f < frames; f++)
				queue_frame(target, pixel_pattern_t'($urandom_range(0, 4)));
			random_pixels += frames * target;
			// an unfinished frame carries into the next size setting
			if (target > 1 && $urandom_range(0, 3) == 0) begin
				frames = $urandom_range(1, target - 1);
				queue_frame(frames, PAT_RANDOM);
				random_pixels += frames;
			end
			wait_idle();
		end

		$display("%0d pixels sent, %0d frame results checked, %0d register writes",
			pixels_pushed, frames_checked, config_writes);
		$display("covered: black, flat and full-swing frames, clamped sizes, resizing mid-frame");
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#(64'd8_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
hdl/gis_pkg.sv
hdl/gis_if.sv
hdl/gis_divider.sv
hdl/gray_image_statistics_unit.sv
hdl/gis_checker.sv
dv/testbench.sv
